// ===== design/piecewise_linear_cell_calibration_defines.svh =====
// Assertion macros shared by the calibration block.
`ifndef PIECEWISE_LINEAR_CELL_CALIBRATION_DEFINES_SVH
`define PIECEWISE_LINEAR_CELL_CALIBRATION_DEFINES_SVH

`ifndef SYNTH
`define PLCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PLCC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLCC_ASSERT(lbl, prop, msg)
`define PLCC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== design/plcc_pkg.sv =====
package plcc_pkg;

  typedef enum logic [1:0] {
    CMD_CONVERT  = 2'd0,
    CMD_WR_BP    = 2'd1,
    CMD_WR_SLOPE = 2'd2,
    CMD_WR_ICPT  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SEG_RD,
    ST_MUL,
    ST_ADD,
    ST_FIN
  } state_t;

  localparam int SAMPLE_W = 12;
  localparam int VALUE_W  = 32;
  localparam int PROD_W   = 45;
  localparam int SUM_W    = 47;

endpackage

// ===== design/piecewise_linear_cell_calibration.sv =====
// Channel  Direction  Handshake          Fields
// in       input      in_valid/in_ready  command channel cell_req level sample table_value
// out      output     out_valid/out_ready millivolts below_range above_range
//
// A table write leaves the sequencer idle and gives no word on the output.
// A convert ends after the first breakpoint read when the sample lies below the first
// breakpoint; otherwise the breakpoint search reads one entry per cycle through the
// single read port of the breakpoint memory, then one multiply and one add stage
// follow. The next word is accepted once the result is queued.
// Reset clears the sequencer and the output valid; the tables hold no reset value.
// A stalled output word holds; a new word may be accepted while it waits.
`include "piecewise_linear_cell_calibration_defines.svh"

module piecewise_linear_cell_calibration
  import plcc_pkg::*;
#(
  parameter int CHANNELS = 16,
  parameter int CELLS    = 1024,
  parameter int SEGMENTS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [3:0]         in_channel,
  input  logic [9:0]         in_cell_req,
  input  logic [4:0]         in_level,
  input  logic [11:0]        in_sample,
  input  logic signed [31:0] in_table_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_millivolts,
  output logic               out_below_range,
  output logic               out_above_range
);

  localparam int BP_PER   = SEGMENTS + 1;
  localparam int CELL_TOT = CHANNELS * CELLS;
  localparam int BP_DEPTH = CELL_TOT * BP_PER;
  localparam int SG_DEPTH = CELL_TOT * SEGMENTS;
  localparam int BASE_W   = (CELL_TOT > 1) ? $clog2(CELL_TOT) : 1;
  localparam int BP_AW    = (BP_DEPTH > 1) ? $clog2(BP_DEPTH) : 1;
  localparam int SG_AW    = (SG_DEPTH > 1) ? $clog2(SG_DEPTH) : 1;
  localparam int LVL_W    = $clog2(SEGMENTS + 2);
  localparam int SEG_W    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

  logic [SAMPLE_W-1:0]       bp_mem [BP_DEPTH];
  logic signed [VALUE_W-1:0] slope_mem [SG_DEPTH];
  logic signed [VALUE_W-1:0] icpt_mem [SG_DEPTH];

  state_t                    state_r, state_nxt;
  logic [BASE_W-1:0]         base_r, base_nxt;
  logic [SAMPLE_W-1:0]       smp_r, smp_nxt;
  logic [LVL_W-1:0]          k_r, k_nxt;
  logic [LVL_W-1:0]          pend_k_r, pend_k_nxt;
  logic                      pend_r, pend_nxt;
  logic [SEG_W-1:0]          seg_r, seg_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [VALUE_W-1:0] res_mv_r, res_mv_nxt;
  logic                      res_below_r, res_below_nxt;
  logic                      res_above_r, res_above_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_mv_r;
  logic                      out_below_r, out_above_r;

  logic [SAMPLE_W-1:0]       bp_q;
  logic signed [VALUE_W-1:0] slope_q, icpt_q;
  logic                      in_acc, addr_ok, out_free, out_load;
  logic [BASE_W-1:0]         in_base;
  logic                      bp_we, slope_we, icpt_we, bp_re, seg_re;
  logic [BP_AW-1:0]          bp_waddr, bp_raddr;
  logic [SG_AW-1:0]          sg_waddr, sg_raddr;
  logic signed [SUM_W-1:0]   sum_w;
  logic signed [SUM_W-9:0]   q_w;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign addr_ok  = (int'(in_channel) < CHANNELS) && (int'(in_cell_req) < CELLS);
  assign in_base  = BASE_W'(in_channel) * BASE_W'(CELLS) + BASE_W'(in_cell_req);

  assign bp_waddr = BP_AW'(in_base) * BP_AW'(BP_PER) + BP_AW'(in_level);
  assign sg_waddr = SG_AW'(in_base) * SG_AW'(SEGMENTS) + SG_AW'(in_level);
  assign bp_raddr = BP_AW'(base_r) * BP_AW'(BP_PER) + BP_AW'(k_r);
  assign sg_raddr = SG_AW'(base_r) * SG_AW'(SEGMENTS) + SG_AW'(seg_r);

  assign bp_we    = in_acc && (cmd_t'(in_command) == CMD_WR_BP) && addr_ok
                    && (int'(in_level) <= SEGMENTS);
  assign slope_we = in_acc && (cmd_t'(in_command) == CMD_WR_SLOPE) && addr_ok
                    && (int'(in_level) < SEGMENTS);
  assign icpt_we  = in_acc && (cmd_t'(in_command) == CMD_WR_ICPT) && addr_ok
                    && (int'(in_level) < SEGMENTS);
  assign bp_re    = (state_r == ST_SEARCH) && (k_r <= LVL_W'(SEGMENTS));
  assign seg_re   = (state_r == ST_SEG_RD);

  always_ff @(posedge clk) begin
    if (bp_we) begin
      bp_mem[bp_waddr] <= in_sample;
    end
    if (bp_re) begin
      bp_q <= bp_mem[bp_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (slope_we) begin
      slope_mem[sg_waddr] <= in_table_value;
    end
    if (seg_re) begin
      slope_q <= slope_mem[sg_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (icpt_we) begin
      icpt_mem[sg_waddr] <= in_table_value;
    end
    if (seg_re) begin
      icpt_q <= icpt_mem[sg_raddr];
    end
  end

  // Floor of (sum + 1/2 LSB) gives round to nearest with ties toward plus infinity.
  assign sum_w = SUM_W'(prod_r) + SUM_W'($signed({icpt_q, 8'b0})) + SUM_W'(128);
  assign q_w   = sum_w[SUM_W-1:8];

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    smp_nxt       = smp_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    pend_k_nxt    = pend_k_r;
    seg_nxt       = seg_r;
    prod_nxt      = prod_r;
    res_mv_nxt    = res_mv_r;
    res_below_nxt = res_below_r;
    res_above_nxt = res_above_r;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (cmd_t'(in_command) == CMD_CONVERT)) begin
          base_nxt      = in_base;
          smp_nxt       = in_sample;
          k_nxt         = '0;
          pend_nxt      = 1'b0;
          res_mv_nxt    = '0;
          res_below_nxt = 1'b0;
          res_above_nxt = 1'b0;
          state_nxt     = addr_ok ? ST_SEARCH : ST_FIN;
        end
      end
      ST_SEARCH: begin
        pend_nxt = bp_re;
        if (bp_re) begin
          pend_k_nxt = k_r;
          k_nxt      = k_r + LVL_W'(1);
        end
        if (pend_r) begin
          if (pend_k_r == '0) begin
            if (smp_r < bp_q) begin
              res_below_nxt = 1'b1;
              state_nxt     = ST_FIN;
            end
          end else if (smp_r < bp_q) begin
            seg_nxt   = SEG_W'(pend_k_r - LVL_W'(1));
            state_nxt = ST_SEG_RD;
          end else if (pend_k_r == LVL_W'(SEGMENTS)) begin
            seg_nxt       = SEG_W'(SEGMENTS - 1);
            res_above_nxt = 1'b1;
            state_nxt     = ST_SEG_RD;
          end
        end
      end
      ST_SEG_RD: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = $signed({1'b0, smp_r}) * slope_q;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        if (q_w[SUM_W-9:VALUE_W-1] != {(SUM_W-7-VALUE_W){q_w[SUM_W-9]}}) begin
          res_mv_nxt = q_w[SUM_W-9] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                    : {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
          res_mv_nxt = q_w[VALUE_W-1:0];
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    smp_r       <= smp_nxt;
    k_r         <= k_nxt;
    pend_k_r    <= pend_k_nxt;
    seg_r       <= seg_nxt;
    prod_r      <= prod_nxt;
    res_mv_r    <= res_mv_nxt;
    res_below_r <= res_below_nxt;
    res_above_r <= res_above_nxt;
    if (out_load) begin
      out_mv_r    <= res_mv_r;
      out_below_r <= res_below_r;
      out_above_r <= res_above_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_millivolts  = out_mv_r;
  assign out_below_range = out_below_r;
  assign out_above_range = out_above_r;

  `PLCC_ASSERT(a_flags_excl, out_valid |-> !(out_below_range && out_above_range), "both range flags set")
  `PLCC_ASSERT(a_below_zero, out_valid && out_below_range |-> out_millivolts == '0, "below range word is not zero")
  `PLCC_ASSERT(a_write_1cyc, in_acc && (cmd_t'(in_command) != CMD_CONVERT) |=> state_r == ST_IDLE, "table write left the idle state")
  `PLCC_ASSERT(a_search_bound, state_r == ST_SEARCH |-> k_r <= LVL_W'(SEGMENTS + 1), "search ran past the top breakpoint")
  `PLCC_ASSERT_RST(a_rst_clear, !rst_n |=> !out_valid && in_ready, "reset did not clear the sequencer")

endmodule
